// ===== rtl/uad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uad_pkg
// shared types, format codes, ascii constants and the decimal place table
// ----------------------------------------------------------------------------
package uad_pkg;

	localparam int VALUE_WIDTH = 32;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	// number of decimal digits of the largest value
	function automatic int dec_digit_count();
		logic [VALUE_WIDTH+3:0] p;
		int n;
		p = (VALUE_WIDTH+4)'(10);
		n = 1;
		for (int i = 0; i < 20; i++) begin
			if (p <= (VALUE_WIDTH+4)'({VALUE_WIDTH{1'b1}})) begin
				n = n + 1;
				p = (VALUE_WIDTH+4)'(p * 10);
			end
		end
		return n;
	endfunction

	localparam int DEC_DIGITS = dec_digit_count();
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int IDX_W      = $clog2(DEC_DIGITS);

	typedef logic [IDX_W-1:0] idx_t;
	typedef value_t pow_tab_t [DEC_DIGITS];

	function automatic pow_tab_t pow10_table();
		pow_tab_t t;
		value_t p;
		p = value_t'(1);
		for (int i = 0; i < DEC_DIGITS; i++) begin
			t[i] = p;
			p = value_t'(p * 10);
		end
		return t;
	endfunction

	localparam pow_tab_t POW10 = pow10_table();

	localparam idx_t DEC_TOP = idx_t'(DEC_DIGITS - 1);
	localparam idx_t HEX_TOP = idx_t'(HEX_DIGITS - 1);

	// format codes
	localparam logic [1:0] FMT_DEC       = 2'd0;
	localparam logic [1:0] FMT_HEX_LOWER = 2'd1;
	localparam logic [1:0] FMT_HEX_UPPER = 2'd2;
	localparam logic [1:0] FMT_NONE      = 2'd3;

	localparam logic [6:0] ASCII_ZERO    = 7'd48;
	localparam logic [6:0] ASCII_UPPER_A = 7'd65;
	localparam logic [6:0] ASCII_LOWER_A = 7'd97;
	localparam logic [3:0] MAX_NUMERAL   = 4'd9;
	localparam logic [3:0] DIGIT_TEN     = 4'd10;

	function automatic logic [6:0] digit_ascii(logic [3:0] d, logic [1:0] fmt);
		logic [6:0] c;
		if (d <= MAX_NUMERAL) begin
			c = ASCII_ZERO + 7'(d);
		end else if (fmt == FMT_HEX_UPPER) begin
			c = ASCII_UPPER_A + 7'(d - DIGIT_TEN);
		end else begin
			c = ASCII_LOWER_A + 7'(d - DIGIT_TEN);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/unsigned_to_ascii_digits.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// converts an unsigned value to ascii digits, decimal or hex, msd first
//
// command port: start with value and func is taken when busy is low. func 0
// gives decimal, 1 lower-case hex, 2 upper-case hex; func 3 is dropped with
// no output and the block stays idle.
// each digit appears on digit_char for one cycle with strobe high; last is
// high on the final digit. a zero value gives the single digit '0'.
// the command is loaded first, then the leading place search steps up
// one place at a time (up to number of digits - 1 steps), then each digit
// is resolved a bit at a time by one shared compare-and-subtract unit,
// weights 8, 4, 2, 1 times the place value.
// the first strobe follows the search once all bits of the first digit are
// resolved; busy falls at the edge that registers the last digit, so a new
// item may start while that digit is shown.
// reset clears the sequencer and the strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [uad_pkg::VALUE_WIDTH-1:0] value,
	input  wire logic [1:0]                 func,
	output logic                            strobe,
	output logic [6:0]                      digit_char,
	output logic                            last
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DIGIT  = 2'd2;

	localparam int EXT_W = uad_pkg::VALUE_WIDTH + 3;

	logic [1:0]            state_q;
	uad_pkg::value_t       rem_q;
	uad_pkg::idx_t         place_idx_q;
	logic [1:0]            bit_q;
	logic [3:0]            digit_q;
	logic [1:0]            fmt_q;
	logic                  strobe_q;
	logic [6:0]            char_q;
	logic                  last_q;

	uad_pkg::idx_t         idx_next;
	uad_pkg::idx_t         idx_top;
	uad_pkg::value_t       place_cur;
	uad_pkg::value_t       place_up;
	logic [EXT_W-1:0]      trial;
	logic                  fits;
	logic [3:0]            digit_new;

	function automatic uad_pkg::value_t place_value(uad_pkg::idx_t k, logic [1:0] fmt);
		uad_pkg::value_t p;
		if (fmt == uad_pkg::FMT_DEC) begin
			p = uad_pkg::POW10[k];
		end else begin
			p = uad_pkg::value_t'(1) << {k, 2'b00};
		end
		return p;
	endfunction

	assign idx_next  = place_idx_q + 1'b1;
	assign idx_top   = (fmt_q == uad_pkg::FMT_DEC) ? uad_pkg::DEC_TOP : uad_pkg::HEX_TOP;
	assign place_cur = place_value(place_idx_q, fmt_q);
	assign place_up  = (place_idx_q == idx_top) ? '0 : place_value(idx_next, fmt_q);

	// shared compare-and-subtract unit
	assign trial     = {3'b000, place_cur} << bit_q;
	assign fits      = (trial <= {3'b000, rem_q});
	assign digit_new = digit_q | (4'(fits) << bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			place_idx_q <= '0;
			bit_q       <= '0;
			digit_q     <= '0;
			fmt_q       <= uad_pkg::FMT_DEC;
			strobe_q    <= 1'b0;
			char_q      <= uad_pkg::ASCII_ZERO;
			last_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start && func != uad_pkg::FMT_NONE) begin
						state_q     <= ST_SEARCH;
						rem_q       <= value;
						fmt_q       <= func;
						place_idx_q <= '0;
					end
				end
				ST_SEARCH: begin
					if (place_idx_q != idx_top && place_up <= rem_q) begin
						place_idx_q <= idx_next;
					end else begin
						state_q <= ST_DIGIT;
						bit_q   <= 2'd3;
						digit_q <= '0;
					end
				end
				ST_DIGIT: begin
					if (fits) begin
						rem_q <= rem_q - trial[uad_pkg::VALUE_WIDTH-1:0];
					end
					if (bit_q == 2'd0) begin
						strobe_q <= 1'b1;
						char_q   <= uad_pkg::digit_ascii(digit_new, fmt_q);
						last_q   <= (place_idx_q == '0);
						digit_q  <= '0;
						bit_q    <= 2'd3;
						if (place_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							place_idx_q <= place_idx_q - 1'b1;
						end
					end else begin
						digit_q <= digit_new;
						bit_q   <= bit_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = strobe_q;
	assign digit_char = char_q;
	assign last       = last_q;

`ifndef ASSERT_OFF
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("last digit shown while still busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final digit shown while idle");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && $past(func) != uad_pkg::FMT_NONE)
		else $error("conversion began without a valid start");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char >= uad_pkg::ASCII_ZERO && digit_char <= 7'd102))
		else $error("digit character out of range");

	a_strobe_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("digit produced without a running conversion");
`endif

endmodule
`default_nettype wire

// ===== verif/uad_digit_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uad_digit_checker
// watches the command and digit ports of unsigned_to_ascii_digits, works out
// the digit string of every accepted value and compares each strobed digit
// with the oldest expected one, counting every mismatch and stray digit
// ----------------------------------------------------------------------------
module uad_digit_checker
	import uad_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       busy,
	input  wire value_t     value,
	input  wire logic [1:0] func,
	input  wire logic       strobe,
	input  wire logic [6:0] digit_char,
	input  wire logic       last,
	output int              error_count,
	output int              digits_pending
);

	typedef struct packed {
		logic [6:0] code;
		logic       final_digit;
	} ascii_digit_t;

	ascii_digit_t expected_digits[$];

	function automatic void predict_digits(value_t num, logic [1:0] fmt);
		logic [63:0] radix;
		logic [63:0] place;
		logic [63:0] rest;
		logic [63:0] d;
		ascii_digit_t e;
		if (fmt == FMT_NONE) begin
			return;
		end
		radix = (fmt == FMT_DEC) ? 64'd10 : 64'd16;
		rest  = 64'(num);
		place = 64'd1;
		while (rest / place >= radix) begin
			place = place * radix;
		end
		while (place != 0) begin
			d     = rest / place;
			rest  = rest % place;
			place = place / radix;
			if (d <= 64'(MAX_NUMERAL)) begin
				e.code = ASCII_ZERO + 7'(d);
			end else if (fmt == FMT_HEX_UPPER) begin
				e.code = ASCII_UPPER_A + 7'(d - 64'd10);
			end else begin
				e.code = ASCII_LOWER_A + 7'(d - 64'd10);
			end
			e.final_digit = (place == 0);
			expected_digits.push_back(e);
		end
	endfunction

	always @(posedge clk) begin
		ascii_digit_t e;
		if (arst_n) begin
			if (strobe === 1'b1) begin
				if (expected_digits.size() == 0) begin
					$display("%0t: digit with none expected, got char %h last %b",
						$time, digit_char, last);
					error_count++;
				end else begin
					e = expected_digits.pop_front();
					if (digit_char !== e.code) begin
						$display("%0t: digit_char mismatch, expected %h, actual %h",
							$time, e.code, digit_char);
						error_count++;
					end
					if (last !== e.final_digit) begin
						$display("%0t: last mismatch, expected %b, actual %b",
							$time, e.final_digit, last);
						error_count++;
					end
				end
			end else if (strobe !== 1'b0) begin
				$display("%0t: strobe unknown, expected 0 or 1, actual %b", $time, strobe);
				error_count++;
			end
			if (start === 1'b1 && busy === 1'b0) begin
				predict_digits(value, func);
			end
		end
		digits_pending = expected_digits.size();
	end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// drives unsigned_to_ascii_digits with directed values (zero, single digits,
// radix boundaries, the largest value, the dropped format code) and then
// random values in all formats with random idle bursts; the digit checker
// predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb;
	import uad_pkg::*;

	logic       clk    = 1'b0;
	logic       arst_n = 1'b0;
	logic       start  = 1'b0;
	value_t     value  = '0;
	logic [1:0] func   = FMT_DEC;
	wire logic  busy;
	wire logic  strobe;
	wire logic [6:0] digit_char;
	wire logic  last;
	int         error_count;
	int         digits_pending;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	unsigned_to_ascii_digits u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.func       (func),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

	uad_digit_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.value          (value),
		.func           (func),
		.strobe         (strobe),
		.digit_char     (digit_char),
		.last           (last),
		.error_count    (error_count),
		.digits_pending (digits_pending)
	);

	task automatic send_item(input value_t v, input logic [1:0] f);
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		func  <= f;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic pause(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			value <= value_t'($urandom);
			func  <= 2'($urandom);
		end
	endtask

	// mixes full-range values, short values and values around radix powers
	function automatic value_t pick_value();
		logic [63:0] p;
		int k;
		value_t v;
		case ($urandom_range(0, 3))
			0: v = value_t'($urandom);
			1: v = value_t'($urandom) >> $urandom_range(0, 31);
			2: begin
				p = 64'd1;
				k = $urandom_range(0, 9);
				repeat (k) p = p * 64'd10;
				v = value_t'(p + 64'($urandom_range(0, 2)) - 64'd1);
			end
			default: begin
				k = $urandom_range(0, 7);
				p = 64'd1 << (4 * k);
				v = value_t'(p + 64'($urandom_range(0, 2)) - 64'd1);
			end
		endcase
		return v;
	endfunction

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(32'd0, FMT_DEC);
		send_item(32'd0, FMT_HEX_LOWER);
		send_item(32'd0, FMT_HEX_UPPER);
		send_item(32'd1, FMT_DEC);
		send_item(32'd9, FMT_DEC);
		send_item(32'd10, FMT_DEC);
		send_item(32'd15, FMT_HEX_LOWER);
		send_item(32'd16, FMT_HEX_UPPER);
		send_item(32'd999_999_999, FMT_DEC);
		send_item(32'd1_000_000_000, FMT_DEC);
		send_item(32'hFFFF_FFFF, FMT_DEC);
		send_item(32'hFFFF_FFFF, FMT_HEX_LOWER);
		send_item(32'hFFFF_FFFF, FMT_HEX_UPPER);
		send_item(32'hABCD_EF01, FMT_HEX_LOWER);
		send_item(32'hABCD_EF01, FMT_HEX_UPPER);
		send_item(32'h8000_0000, FMT_HEX_UPPER);
		send_item(32'h0FFF_FFFF, FMT_HEX_LOWER);
		send_item(32'h1000_0000, FMT_DEC);
		send_item(32'h1234_5678, FMT_NONE);
		send_item(32'h5555_AAAA, FMT_DEC);
		send_item(32'hAAAA_5555, FMT_HEX_UPPER);
		send_item(32'h0000_0000, FMT_NONE);
		pause(3);

		for (int i = 0; i < 460; i++) begin
			if (i < 400 && $urandom_range(0, 3) == 0) begin
				pause($urandom_range(1, 5));
			end
			if (i < 400 && $urandom_range(0, 19) == 0) begin
				send_item(value_t'($urandom), FMT_NONE);
			end
			send_item(pick_value(), 2'($urandom_range(0, 2)));
		end

		@(negedge clk);
		start <= 1'b0;
		wait (digits_pending == 0);
		repeat (60) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire
